@@ src/ppl_pkg.sv @@
`timescale 1ns / 1ps
package ppl_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int DIV_STEPS  = 7;
    localparam int SHIFT_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WORK     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE = 2'd3;

    localparam logic [1:0] STATUS_NORMAL   = 2'd0;
    localparam logic [1:0] STATUS_WARNING  = 2'd1;
    localparam logic [1:0] STATUS_CRITICAL = 2'd2;

    localparam logic [31:0] HOLDOFF_MS    = 32'd5000;
    localparam logic [31:0] RECOVER_MS    = 32'd60000;
    // floor(x*85/100) == (x*445655) >> 19 for every 7 bit x
    localparam logic [18:0] FLOOD_RECIP   = 19'd445655;
    localparam int          FLOOD_SHIFT   = 19;
    localparam logic [6:0]  FLOOR_POWER   = 7'd30;
    localparam logic [6:0]  FULL_POWER    = 7'd100;
    localparam logic [6:0]  FLOOD_STEP    = 7'd15;
    localparam logic [6:0]  REDUCTION_CAP = 7'd50;
    localparam logic [5:0]  EXTRA_STEP    = 6'd10;
    localparam logic [7:0]  FREQUENT_CNT  = 8'd3;
    localparam logic [7:0]  FLOOD_MAX     = 8'd255;
    localparam logic [5:0]  RECOVER_STEP  = 6'd5;

    typedef struct packed {
        logic signed [15:0] pressure_sample;
        logic [31:0]        now_ms;
        logic [6:0]         heater_now;
    } sample_t;

    typedef struct packed {
        logic [6:0] power_percent;
        logic       heater_write;
        logic [6:0] heater_new;
        logic [1:0] pressure_status;
        logic       override_on;
        logic [5:0] reduction_now;
    } result_t;

    typedef struct packed {
        logic               capture;
        logic               eval;
        logic               div_step;
        logic [SHIFT_W-1:0] div_shift;
        logic               load;
    } ppl_cmd_t;

    typedef struct packed {
        logic need_div;
    } ppl_stat_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_LOAD = 4'b1000
    } ppl_state_t;

endpackage

@@ src/ppl_ctrl.sv @@
`timescale 1ns / 1ps
module ppl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  ppl_pkg::ppl_stat_t stat,
    output ppl_pkg::ppl_cmd_t  cmd
);

    ppl_pkg::ppl_state_t state_reg, state_next;
    logic [ppl_pkg::SHIFT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppl_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.div_shift  = cnt_reg;
        sample_ready   = 1'b0;

        // output slot drains independently of the work in progress
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ppl_pkg::S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ppl_pkg::S_EVAL;
                end
            end
            ppl_pkg::S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (stat.need_div)
                begin
                    cnt_next   = ppl_pkg::SHIFT_W'(ppl_pkg::DIV_STEPS - 1);
                    state_next = ppl_pkg::S_DIV;
                end
                else
                begin
                    state_next = ppl_pkg::S_LOAD;
                end
            end
            ppl_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ppl_pkg::S_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ppl_pkg::S_LOAD:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ppl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ppl_pkg::S_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

@@ src/ppl_datapath.sv @@
`timescale 1ns / 1ps
module ppl_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ppl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  ppl_pkg::sample_t                 sample,
    input  ppl_pkg::ppl_cmd_t                cmd,
    output ppl_pkg::ppl_stat_t               stat,
    output ppl_pkg::result_t                 result
);

    // configuration
    logic [14:0] work_reg, warn_reg, crit_reg;
    logic [7:0]  override_reg;

    // block state
    logic [31:0] last_event_reg, last_event_next;
    logic [7:0]  flood_total_reg, flood_total_next;
    logic [5:0]  reduction_reg, reduction_next;

    // per transaction
    ppl_pkg::sample_t in_reg;
    logic [1:0]  status_reg;
    logic        hw_reg, ovr_reg, zero_reg, full_reg;
    logic [6:0]  hnew_reg, ovr_pow_reg;
    logic [5:0]  red_used_reg;
    logic [21:0] rem_reg;
    logic [6:0]  quo_reg;
    ppl_pkg::result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg     <= '0;
            warn_reg     <= '0;
            crit_reg     <= '0;
            override_reg <= 8'hFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppl_pkg::CFG_WORK:     work_reg     <= cfg_data;
                ppl_pkg::CFG_WARN:     warn_reg     <= cfg_data;
                ppl_pkg::CFG_CRIT:     crit_reg     <= cfg_data;
                ppl_pkg::CFG_OVERRIDE: override_reg <= cfg_data[7:0];
                default:               work_reg     <= work_reg;
            endcase
        end
    end

    // evaluation of the captured sample
    logic        p_nonneg, crit_hit, warn_hit, ovr_act, flood;
    logic [14:0] pu;
    logic [31:0] elapsed;
    logic [7:0]  flood_inc;
    logic [6:0]  red_sum, red_cap;
    logic [5:0]  red_flood, red_used;
    logic [25:0] hprod;
    logic [6:0]  hq, hnew;
    logic [1:0]  status;
    logic        ramp_zero, ramp_full;
    logic [6:0]  ovr_pow;

    always_comb
    begin
        p_nonneg  = !in_reg.pressure_sample[15];
        pu        = in_reg.pressure_sample[14:0];
        crit_hit  = p_nonneg && (pu >= crit_reg);
        warn_hit  = p_nonneg && (pu >= warn_reg);
        if (crit_hit)
            status = ppl_pkg::STATUS_CRITICAL;
        else if (warn_hit)
            status = ppl_pkg::STATUS_WARNING;
        else
            status = ppl_pkg::STATUS_NORMAL;

        ovr_act = !override_reg[7];
        ovr_pow = (override_reg[6:0] > ppl_pkg::FULL_POWER) ? ppl_pkg::FULL_POWER
                                                             : override_reg[6:0];

        elapsed = in_reg.now_ms - last_event_reg;
        flood   = !ovr_act && crit_hit && (elapsed >= ppl_pkg::HOLDOFF_MS);

        flood_inc = (flood_total_reg == ppl_pkg::FLOOD_MAX) ? flood_total_reg
                                                            : flood_total_reg + 8'd1;
        red_sum   = 7'(reduction_reg) + ppl_pkg::FLOOD_STEP;
        red_cap   = (red_sum > ppl_pkg::REDUCTION_CAP) ? ppl_pkg::REDUCTION_CAP : red_sum;
        red_flood = red_cap[5:0] +
                    ((flood_inc > ppl_pkg::FREQUENT_CNT) ? ppl_pkg::EXTRA_STEP : 6'd0);
        red_used  = flood ? red_flood : reduction_reg;

        hprod = 26'(in_reg.heater_now) * 26'(ppl_pkg::FLOOD_RECIP);
        hq    = hprod[ppl_pkg::FLOOD_SHIFT +: 7];
        if (hq < ppl_pkg::FLOOR_POWER)
            hnew = ppl_pkg::FLOOR_POWER;
        else if (hq > ppl_pkg::FULL_POWER)
            hnew = ppl_pkg::FULL_POWER;
        else
            hnew = hq;

        ramp_zero = !p_nonneg || (pu == '0);
        ramp_full = !ramp_zero && (pu >= work_reg);

        last_event_next  = last_event_reg;
        flood_total_next = flood_total_reg;
        reduction_next   = reduction_reg;
        if (!ovr_act)
        begin
            if (flood)
            begin
                last_event_next  = in_reg.now_ms;
                flood_total_next = flood_inc;
                reduction_next   = red_flood;
            end
            else if ((reduction_reg != '0) && (elapsed > ppl_pkg::RECOVER_MS))
            begin
                reduction_next  = (reduction_reg >= ppl_pkg::RECOVER_STEP)
                                  ? reduction_reg - ppl_pkg::RECOVER_STEP : 6'd0;
                last_event_next = in_reg.now_ms;
            end
        end
    end

    assign stat.need_div = !ovr_act && !ramp_zero && !ramp_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_event_reg  <= '0;
            flood_total_reg <= '0;
            reduction_reg   <= '0;
        end
        else if (cmd.eval)
        begin
            last_event_reg  <= last_event_next;
            flood_total_reg <= flood_total_next;
            reduction_reg   <= reduction_next;
        end
    end

    // restoring divider, one quotient bit per cycle, quotient below 100
    logic [21:0] dshift, rem_next;
    logic [6:0]  quo_next;

    always_comb
    begin
        dshift   = 22'(work_reg) << cmd.div_shift;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (rem_reg >= dshift)
        begin
            rem_next = rem_reg - dshift;
            quo_next = quo_reg | (7'd1 << cmd.div_shift);
        end
    end

    logic [6:0] base_pow, power;

    always_comb
    begin
        if (ovr_reg)
            base_pow = ovr_pow_reg;
        else if (zero_reg)
            base_pow = 7'd0;
        else if (full_reg)
            base_pow = ppl_pkg::FULL_POWER;
        else
            base_pow = quo_reg;

        if (ovr_reg)
            power = base_pow;
        else if (base_pow > 7'(red_used_reg))
            power = base_pow - 7'(red_used_reg);
        else
            power = 7'd0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= sample;
        end
        if (cmd.eval)
        begin
            status_reg   <= status;
            hw_reg       <= flood;
            hnew_reg     <= flood ? hnew : 7'd0;
            ovr_reg      <= ovr_act;
            ovr_pow_reg  <= ovr_pow;
            zero_reg     <= ramp_zero;
            full_reg     <= ramp_full;
            red_used_reg <= red_used;
            rem_reg      <= 22'(pu) * 22'(ppl_pkg::FULL_POWER);
            quo_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.load)
        begin
            result_reg.power_percent   <= power;
            result_reg.heater_write    <= hw_reg;
            result_reg.heater_new      <= hnew_reg;
            result_reg.pressure_status <= status_reg;
            result_reg.override_on     <= ovr_reg;
            result_reg.reduction_now   <= reduction_reg;
        end
    end

    assign result = result_reg;

endmodule

@@ src/pressure_power_limiter.sv @@
`timescale 1ns / 1ps
// a sample is captured, evaluated, run through the ramp divider if needed, then loaded
// the divider is a restoring loop giving one of 7 quotient bits per cycle
// one sample in flight; the load stalls while the output register is full and not read
// a finished result waits in an output register while the next sample is taken
// reset: async active low, thresholds and state cleared, override set to disabled
module pressure_power_limiter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ppl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  ppl_pkg::sample_t               sample,
    output logic                           result_valid,
    input  logic                           result_ready,
    output ppl_pkg::result_t               result
);

    ppl_pkg::ppl_cmd_t  cmd;
    ppl_pkg::ppl_stat_t stat;

    ppl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    ppl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule
